### rtl/abc_pkg.sv
package abc_pkg;
  localparam int CornerCount = 8;
  localparam int CoordFrac = 8;
  localparam int OutWidth = 24;
  localparam logic [2:0] LastCorner = 3'd7;
  // Axes that take the max value, bit 0 = x, indexed by corner number
  function automatic logic [2:0] corner_sel(input logic [2:0] k);
    logic [2:0] s;
    unique case (k)
      3'd0: s = 3'b000;
      3'd1: s = 3'b001;
      3'd2: s = 3'b010;
      3'd3: s = 3'b100;
      3'd4: s = 3'b111;
      3'd5: s = 3'b110;
      3'd6: s = 3'b101;
      3'd7: s = 3'b011;
      default: s = 3'b000;
    endcase
    return s;
  endfunction
endpackage

### rtl/aabb_to_oriented_box_corners_core.sv
// From request accept, corner 0 passes stage registers A to E into the output register.
// Throughput: one corner per cycle while out_ready allows; stage C holds the box while
//   its corners are issued, and stages A and B can take the next boxes meanwhile.
// Pipeline: latch, scale/product and matrix stages, then per-corner multiply, sum, round stages.
// Reset: rst_n synchronous active low clears all valid bits and the corner counter.
module aabb_to_oriented_box_corners_core import abc_pkg::*; #(
  parameter int COORD_WIDTH = 20,
  parameter int QUAT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [59:0] in_box_min,
  input  logic [59:0] in_box_max,
  input  logic [59:0] in_scale_vec,
  input  logic [59:0] in_position,
  input  logic [63:0] in_orientation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] out_corner_x,
  output logic signed [23:0] out_corner_y,
  output logic signed [23:0] out_corner_z,
  output logic [2:0]  out_corner_index,
  output logic        out_last_corner
);
  localparam int CW = COORD_WIDTH;
  localparam int QW = QUAT_WIDTH;
  localparam int QF = QW - 2;
  localparam int SW = 2 * CW;          // scaled coordinate
  localparam int MW = QW + 4;          // rounded matrix entry
  localparam int PW = SW + MW;         // one product
  localparam int AW = PW + 3;          // sum of three plus position
  localparam int RS = 2 * CoordFrac + QF - 8;
  localparam int QPW = 2 * QW + 3;     // matrix entry before rounding

  logic adv;
  logic a_v_r;

  // Stage A: latch the request
  logic signed [CW-1:0] a_min_r [3], a_max_r [3], a_sc_r [3], a_pos_r [3];
  logic signed [QW-1:0] a_q_r [4];

  // Stage B: scaled coordinates and quaternion products
  logic b_v_r;
  logic signed [SW-1:0] b_smin_r [3], b_smax_r [3];
  logic signed [CW-1:0] b_pos_r [3];
  logic signed [2*QW-1:0] b_qq_r [9];

  // Stage C: held box with rounded matrix; corners issue from here
  logic c_v_r;
  logic [2:0] c_k_r;
  logic signed [SW-1:0] c_smin_r [3], c_smax_r [3];
  logic signed [CW-1:0] c_pos_r [3];
  logic signed [MW-1:0] c_m_r [3][3];

  logic d_v_r, e_v_r, f_v_r;
  logic [2:0] d_k_r, e_k_r;
  logic signed [PW-1:0] d_p_r [3][3];
  logic signed [CW-1:0] d_pos_r [3];
  logic signed [AW-1:0] e_acc_r [3];

  assign adv = !f_v_r || out_ready;
  wire c_last = c_k_r == LastCorner;
  wire c_free = !c_v_r || (adv && c_last);
  wire b_move = c_free;
  wire a_move = !b_v_r || b_move;
  assign in_ready = !a_v_r || a_move;

  function automatic logic signed [MW-1:0] rnd_m(input logic signed [QPW-1:0] v);
    logic signed [QPW-1:0] t;
    t = (v + (QPW'(1) <<< (QF - 1))) >>> QF;
    return t[MW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int i = 0; i < 3; i++) begin
        a_min_r[i] <= in_box_min[i*CW +: CW];
        a_max_r[i] <= in_box_max[i*CW +: CW];
        a_sc_r[i]  <= in_scale_vec[i*CW +: CW];
        a_pos_r[i] <= in_position[i*CW +: CW];
      end
      for (int i = 0; i < 4; i++) a_q_r[i] <= in_orientation[i*QW +: QW];
    end
    if (a_move) begin
      for (int i = 0; i < 3; i++) begin
        b_smin_r[i] <= a_min_r[i] * a_sc_r[i];
        b_smax_r[i] <= a_max_r[i] * a_sc_r[i];
        b_pos_r[i]  <= a_pos_r[i];
      end
      // ww unused; order: xx yy zz xy xz yz wx wy wz
      b_qq_r[0] <= a_q_r[1] * a_q_r[1];
      b_qq_r[1] <= a_q_r[2] * a_q_r[2];
      b_qq_r[2] <= a_q_r[3] * a_q_r[3];
      b_qq_r[3] <= a_q_r[1] * a_q_r[2];
      b_qq_r[4] <= a_q_r[1] * a_q_r[3];
      b_qq_r[5] <= a_q_r[2] * a_q_r[3];
      b_qq_r[6] <= a_q_r[0] * a_q_r[1];
      b_qq_r[7] <= a_q_r[0] * a_q_r[2];
      b_qq_r[8] <= a_q_r[0] * a_q_r[3];
    end
    if (b_move) begin
      logic signed [QPW-1:0] one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      one = QPW'(1) <<< (2 * QF);
      xx = QPW'(b_qq_r[0]); yy = QPW'(b_qq_r[1]); zz = QPW'(b_qq_r[2]);
      xy = QPW'(b_qq_r[3]); xz = QPW'(b_qq_r[4]); yz = QPW'(b_qq_r[5]);
      wx = QPW'(b_qq_r[6]); wy = QPW'(b_qq_r[7]); wz = QPW'(b_qq_r[8]);
      c_m_r[0][0] <= rnd_m(one - 2 * (yy + zz));
      c_m_r[1][0] <= rnd_m(2 * (xy + wz));
      c_m_r[2][0] <= rnd_m(2 * (xz - wy));
      c_m_r[0][1] <= rnd_m(2 * (xy - wz));
      c_m_r[1][1] <= rnd_m(one - 2 * (xx + zz));
      c_m_r[2][1] <= rnd_m(2 * (yz + wx));
      c_m_r[0][2] <= rnd_m(2 * (xz + wy));
      c_m_r[1][2] <= rnd_m(2 * (yz - wx));
      c_m_r[2][2] <= rnd_m(one - 2 * (xx + yy));
      c_smin_r <= b_smin_r;
      c_smax_r <= b_smax_r;
      c_pos_r  <= b_pos_r;
    end
    if (adv) begin
      logic [2:0] sel;
      logic signed [SW-1:0] s [3];
      sel = corner_sel(c_k_r);
      for (int c = 0; c < 3; c++) s[c] = sel[c] ? c_smax_r[c] : c_smin_r[c];
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          d_p_r[r][c] <= PW'(c_m_r[r][c]) * PW'(s[c]);
      d_pos_r <= c_pos_r;
      d_k_r <= c_k_r;
      for (int r = 0; r < 3; r++)
        e_acc_r[r] <= AW'(d_p_r[r][0]) + AW'(d_p_r[r][1]) + AW'(d_p_r[r][2])
                    + (AW'(d_pos_r[r]) <<< (CoordFrac + QF));
      e_k_r <= d_k_r;
      begin
        logic signed [AW-1:0] v [3];
        logic signed [OutWidth-1:0] o [3];
        for (int r = 0; r < 3; r++) begin
          v[r] = (e_acc_r[r] + (AW'(1) <<< (RS - 1))) >>> RS;
          if (v[r] > AW'(8388607)) o[r] = 24'sh7FFFFF;
          else if (v[r] < -AW'(8388608)) o[r] = 24'sh800000;
          else o[r] = v[r][OutWidth-1:0];
        end
        out_corner_x <= o[0];
        out_corner_y <= o[1];
        out_corner_z <= o[2];
      end
      out_corner_index <= e_k_r;
      out_last_corner <= e_k_r == LastCorner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0;
      d_v_r <= 1'b0; e_v_r <= 1'b0; f_v_r <= 1'b0;
      c_k_r <= '0;
    end else begin
      if (in_ready) a_v_r <= in_valid;
      if (a_move) b_v_r <= a_v_r;
      if (b_move) begin
        c_v_r <= b_v_r;
        c_k_r <= '0;
      end else if (adv && c_v_r) begin
        c_k_r <= c_k_r + 3'd1;
      end
      if (adv) begin
        d_v_r <= c_v_r;
        e_v_r <= d_v_r;
        f_v_r <= e_v_r;
      end
    end
  end

  assign out_valid = f_v_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corner_index))
    else $error("result dropped under stall");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_corner == (out_corner_index == LastCorner)))
    else $error("last flag mismatch");
  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !adv |=> $stable(c_k_r))
    else $error("corner counter moved while stalled");
endmodule
